/* src/sbi_pkg.sv */
// shared types and constants for the spectral band integrator
package sbi_pkg;

  localparam int NUM_BANDS = 8;
  localparam int BAND_W    = 3;
  localparam int CFG_AW    = 3;
  localparam int EDGE_W    = 32;
  localparam int WL_W      = 16;
  localparam int REFL_W    = 24;
  localparam int ACC_W     = 56;
  localparam int DIST_W    = WL_W + 1;
  localparam int DM_W      = WL_W + 2;
  localparam int TERM_W    = REFL_W + DM_W + 2;
  localparam int DIV_W     = WL_W + 1;
  localparam int QUO_W     = 23;
  localparam int CNT_W     = 5;

  localparam logic [BAND_W-1:0] BAND_LAST = BAND_W'(NUM_BANDS - 1);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(QUO_W - 1);

  localparam logic signed [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [REFL_W-1:0] VAL_MAX = {1'b0, {(REFL_W-1){1'b1}}};
  localparam logic signed [REFL_W-1:0] VAL_MIN = {1'b1, {(REFL_W-1){1'b0}}};

  typedef struct packed {
    logic [WL_W-1:0]          wavelength;
    logic signed [REFL_W-1:0] reflectance;
    logic                     final_sample;
  } in_t;

  typedef struct packed {
    logic [BAND_W-1:0]        band_index;
    logic signed [REFL_W-1:0] band_value;
    logic                     zero_width;
    logic                     last_band;
  } out_t;

  typedef enum logic [1:0] {
    FILL_EMPTY,
    FILL_NO_LEFT,
    FILL_BOTH
  } fill_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DRD,
    ST_DPREP,
    ST_DLOAD,
    ST_DCHK,
    ST_DITER,
    ST_DOUT
  } state_e;

endpackage

/* src/spectral_band_integrator_unit.sv */
// spectral band integrator: accumulator memory, band sweep and band average divider
// an ordinary sample takes one 8-band read-modify-write sweep over the accumulator
// memory plus pipeline drain; the first sample of a spectrum takes only the drain
// the final sample takes two sweeps (one if it is also the first) and then a divide
// per band by the one-bit-per-cycle divider, plus any output stall
// reset clears band edges, the sample window, valid bits of all sums and both channels
module spectral_band_integrator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sbi_pkg::CFG_AW-1:0]      cfg_addr_i,
  input  logic [sbi_pkg::EDGE_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sbi_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sbi_pkg::out_t                   out_data_o
);

  sbi_pkg::state_e state_q, state_d;

  logic [sbi_pkg::EDGE_W-1:0] edges_q [sbi_pkg::NUM_BANDS];

  sbi_pkg::in_t                     in_q;
  logic                             phase_q;
  logic [sbi_pkg::BAND_W-1:0]       band_q;
  logic [sbi_pkg::WL_W-1:0]         prior_wl_q;
  logic [sbi_pkg::WL_W-1:0]         held_wl_q;
  logic signed [sbi_pkg::REFL_W-1:0] held_refl_q;
  sbi_pkg::fill_e                   fill_q;

  // accumulator memory
  logic [sbi_pkg::ACC_W-1:0]     sum_mem [sbi_pkg::NUM_BANDS];
  logic [sbi_pkg::ACC_W-1:0]     mem_rdata_q;
  logic                          rd_vld_q;
  logic [sbi_pkg::NUM_BANDS-1:0] sum_vld_q;
  logic [sbi_pkg::ACC_W-1:0]     sum_rd;

  // sweep pipeline
  logic                              s1_valid_q, s2_valid_q;
  logic [sbi_pkg::BAND_W-1:0]        s1_band_q, s2_band_q;
  logic                              s1_inside_q, s2_inside_q;
  logic [sbi_pkg::DM_W-1:0]          s1_dm_q;
  logic signed [sbi_pkg::REFL_W-1:0] s1_r_q;
  logic signed [sbi_pkg::TERM_W-1:0] s2_term_q;
  logic signed [sbi_pkg::ACC_W-1:0]  s2_sum_q;

  // divider
  logic                         neg_q, zero_q, sat_q;
  logic [sbi_pkg::WL_W-1:0]     aw_q;
  logic [sbi_pkg::ACC_W-1:0]    mag_q, num_q;
  logic [sbi_pkg::DIV_W-1:0]    rem_q;
  logic [sbi_pkg::QUO_W-1:0]    quo_q;
  logic [sbi_pkg::CNT_W-1:0]    cnt_q;

  logic          out_valid_q;
  sbi_pkg::out_t out_q;

  // control strobes
  logic accept, issue, band_inc, out_free, out_load, pipe_empty;
  logic phase_set, win_upd, win_clr, sum_clr, last_band;

  // stage 0 operands
  logic [sbi_pkg::EDGE_W-1:0]        edge_sel;
  logic [sbi_pkg::WL_W-1:0]          lo, hi, x, left, right, l_cl, r_cl, dl, dr;
  logic signed [sbi_pkg::REFL_W-1:0] r_sel;
  logic                              has_left, has_right, in_band;
  logic [sbi_pkg::DIST_W-1:0]        dsum;
  logic [sbi_pkg::DM_W-1:0]          dm;

  logic signed [sbi_pkg::TERM_W-1:0] prod;
  logic signed [sbi_pkg::ACC_W:0]    acc_ext;
  logic [sbi_pkg::ACC_W-1:0]         acc_sat;
  logic                              mem_we;

  logic signed [sbi_pkg::DIST_W-1:0] wd;
  logic [sbi_pkg::DIV_W-1:0]         div_d;
  logic                              sat_chk;
  logic [sbi_pkg::DIV_W:0]           trial;
  logic                              trial_ge;
  logic signed [sbi_pkg::REFL_W-1:0] value;

  assign last_band  = (band_q == sbi_pkg::BAND_LAST);
  assign pipe_empty = !s1_valid_q && !s2_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sbi_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (fill_q != sbi_pkg::FILL_EMPTY) ? sbi_pkg::ST_SWEEP : sbi_pkg::ST_DRAIN;
        end
      end
      sbi_pkg::ST_SWEEP: begin
        if (last_band) state_d = sbi_pkg::ST_DRAIN;
      end
      sbi_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          if (phase_q) begin
            state_d = sbi_pkg::ST_DRD;
          end else if (in_q.final_sample) begin
            state_d = sbi_pkg::ST_SWEEP;
          end else begin
            state_d = sbi_pkg::ST_IDLE;
          end
        end
      end
      sbi_pkg::ST_DRD:   state_d = sbi_pkg::ST_DPREP;
      sbi_pkg::ST_DPREP: state_d = sbi_pkg::ST_DLOAD;
      sbi_pkg::ST_DLOAD: state_d = sbi_pkg::ST_DCHK;
      sbi_pkg::ST_DCHK: begin
        state_d = (sat_chk || zero_q) ? sbi_pkg::ST_DOUT : sbi_pkg::ST_DITER;
      end
      sbi_pkg::ST_DITER: begin
        if (cnt_q == sbi_pkg::CNT_LAST) state_d = sbi_pkg::ST_DOUT;
      end
      sbi_pkg::ST_DOUT: begin
        if (out_free) state_d = last_band ? sbi_pkg::ST_IDLE : sbi_pkg::ST_DRD;
      end
      default: state_d = sbi_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != sbi_pkg::ST_IDLE);
    accept     = (state_q == sbi_pkg::ST_IDLE) && in_valid_i;
    issue      = (state_q == sbi_pkg::ST_SWEEP);
    out_load   = (state_q == sbi_pkg::ST_DOUT) && out_free;
    band_inc   = issue || out_load;
    phase_set  = (state_q == sbi_pkg::ST_DRAIN) && pipe_empty && !phase_q && in_q.final_sample;
    win_upd    = (state_q == sbi_pkg::ST_DRAIN) && pipe_empty && !phase_q && !in_q.final_sample;
    win_clr    = out_load && last_band;
    sum_clr    = (state_q == sbi_pkg::ST_DPREP);
  end

  // stage 0: band window and neighbor distance
  always_comb begin
    edge_sel = edges_q[band_q];
    lo       = edge_sel[15:0];
    hi       = edge_sel[31:16];
    if (phase_q) begin
      x         = in_q.wavelength;
      r_sel     = in_q.reflectance;
      has_left  = (fill_q != sbi_pkg::FILL_EMPTY);
      left      = held_wl_q;
      has_right = 1'b0;
      right     = '0;
    end else begin
      x         = held_wl_q;
      r_sel     = held_refl_q;
      has_left  = (fill_q == sbi_pkg::FILL_BOTH);
      left      = prior_wl_q;
      has_right = 1'b1;
      right     = in_q.wavelength;
    end
    in_band = (x >= lo) && (x <= hi);
    l_cl    = (left < lo) ? lo : left;
    r_cl    = (right > hi) ? hi : right;
    dl      = (l_cl >= x) ? (l_cl - x) : (x - l_cl);
    dr      = (r_cl >= x) ? (r_cl - x) : (x - r_cl);
    dsum    = (has_left ? {1'b0, dl} : '0) + (has_right ? {1'b0, dr} : '0);
    dm      = (has_left && has_right) ? {1'b0, dsum} : {dsum, 1'b0};
  end

  assign sum_rd = rd_vld_q ? mem_rdata_q : '0;

  // stage 1 product, stage 2 saturating add
  assign prod    = s1_r_q * $signed({1'b0, s1_dm_q});
  assign acc_ext = {s2_sum_q[sbi_pkg::ACC_W-1], s2_sum_q}
                 + {{(sbi_pkg::ACC_W + 1 - sbi_pkg::TERM_W){s2_term_q[sbi_pkg::TERM_W-1]}},
                    s2_term_q};
  always_comb begin
    if (acc_ext[sbi_pkg::ACC_W] != acc_ext[sbi_pkg::ACC_W-1]) begin
      acc_sat = acc_ext[sbi_pkg::ACC_W] ? sbi_pkg::ACC_MIN : sbi_pkg::ACC_MAX;
    end else begin
      acc_sat = acc_ext[sbi_pkg::ACC_W-1:0];
    end
  end
  assign mem_we = s2_valid_q && s2_inside_q;

  // divider arithmetic
  assign wd       = $signed({1'b0, hi}) - $signed({1'b0, lo});
  assign div_d    = {aw_q, 1'b0};
  assign sat_chk  = num_q >= sbi_pkg::ACC_W'({div_d, {sbi_pkg::QUO_W{1'b0}}});
  assign trial    = {rem_q, quo_q[sbi_pkg::QUO_W-1]};
  assign trial_ge = trial >= {1'b0, div_d};

  always_comb begin
    if (zero_q) begin
      value = '0;
    end else if (sat_q) begin
      value = neg_q ? sbi_pkg::VAL_MIN : sbi_pkg::VAL_MAX;
    end else if (neg_q) begin
      value = -$signed({1'b0, quo_q});
    end else begin
      value = $signed({1'b0, quo_q});
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbi_pkg::ST_IDLE;
      phase_q     <= 1'b0;
      band_q      <= '0;
      prior_wl_q  <= '0;
      held_wl_q   <= '0;
      held_refl_q <= '0;
      fill_q      <= sbi_pkg::FILL_EMPTY;
      sum_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < sbi_pkg::NUM_BANDS; k++) begin
        edges_q[k] <= '0;
      end
    end else begin
      state_q    <= state_d;
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
      rd_vld_q   <= sum_vld_q[band_q];
      if (cfg_we_i && (int'(cfg_addr_i) < sbi_pkg::NUM_BANDS)) begin
        edges_q[cfg_addr_i] <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q <= 1'b0;
      end else if (phase_set) begin
        phase_q <= 1'b1;
      end
      if (band_inc) begin
        band_q <= last_band ? '0 : band_q + 1'b1;
      end
      if (mem_we) begin
        sum_vld_q[s2_band_q] <= 1'b1;
      end
      if (sum_clr) begin
        sum_vld_q[band_q] <= 1'b0;
      end
      if (win_upd) begin
        if (fill_q != sbi_pkg::FILL_EMPTY) prior_wl_q <= held_wl_q;
        held_wl_q   <= in_q.wavelength;
        held_refl_q <= in_q.reflectance;
        fill_q      <= (fill_q != sbi_pkg::FILL_EMPTY) ? sbi_pkg::FILL_BOTH
                                                       : sbi_pkg::FILL_NO_LEFT;
      end else if (win_clr) begin
        prior_wl_q  <= '0;
        held_wl_q   <= '0;
        held_refl_q <= '0;
        fill_q      <= sbi_pkg::FILL_EMPTY;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // accumulator memory
  always_ff @(posedge clk_i) begin
    if (mem_we) sum_mem[s2_band_q] <= acc_sat;
    mem_rdata_q <= sum_mem[band_q];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    s1_band_q   <= band_q;
    s1_inside_q <= in_band;
    s1_dm_q     <= dm;
    s1_r_q      <= r_sel;
    s2_band_q   <= s1_band_q;
    s2_inside_q <= s1_inside_q;
    s2_term_q   <= prod;
    s2_sum_q    <= $signed(sum_rd);
    unique case (state_q)
      sbi_pkg::ST_DPREP: begin
        neg_q  <= sum_rd[sbi_pkg::ACC_W-1] ^ wd[sbi_pkg::DIST_W-1];
        zero_q <= (wd == '0);
        aw_q   <= wd[sbi_pkg::DIST_W-1] ? sbi_pkg::WL_W'(-wd) : sbi_pkg::WL_W'(wd);
        mag_q  <= sum_rd[sbi_pkg::ACC_W-1] ? -sum_rd : sum_rd;
      end
      sbi_pkg::ST_DLOAD: begin
        num_q <= mag_q + sbi_pkg::ACC_W'(aw_q);
      end
      sbi_pkg::ST_DCHK: begin
        sat_q <= sat_chk;
        rem_q <= num_q[sbi_pkg::QUO_W +: sbi_pkg::DIV_W];
        quo_q <= num_q[sbi_pkg::QUO_W-1:0];
        cnt_q <= '0;
      end
      sbi_pkg::ST_DITER: begin
        rem_q <= trial_ge ? sbi_pkg::DIV_W'(trial - {1'b0, div_d}) : trial[sbi_pkg::DIV_W-1:0];
        quo_q <= {quo_q[sbi_pkg::QUO_W-2:0], trial_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_q.band_index <= band_q;
      out_q.band_value <= value;
      out_q.zero_width <= zero_q;
      out_q.last_band  <= last_band;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* bench/tb_top.sv */
// self-checking testbench for the spectral band integrator unit
`timescale 1ns / 100ps

module tb_top;

  localparam int SETTLE_CYCLES  = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLDOFF_CYCLES = 3000;
  localparam int HOLDOFF_AFTER  = 120;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_SAMPLES  = 72;
  localparam int REGION_SPAN    = 4096;
  localparam int WL_TOP         = (1 << sbi_pkg::WL_W) - 1;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [sbi_pkg::CFG_AW-1:0] cfg_addr_i  = '0;
  logic [sbi_pkg::EDGE_W-1:0] cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  sbi_pkg::in_t               in_data_i   = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  sbi_pkg::out_t              out_data_o;

  // sample stream waiting for the driver, band averages waiting for the block
  sbi_pkg::in_t  sample_queue[$];
  sbi_pkg::out_t band_result_queue[$];

  // shadow of the block's registers and accumulation state
  logic [sbi_pkg::EDGE_W-1:0]       band_edges [sbi_pkg::NUM_BANDS] = '{default: '0};
  logic signed [sbi_pkg::ACC_W-1:0] band_sums  [sbi_pkg::NUM_BANDS] = '{default: '0};
  logic [sbi_pkg::WL_W-1:0]          prior_wl    = '0;
  logic [sbi_pkg::WL_W-1:0]          held_wl     = '0;
  logic signed [sbi_pkg::REFL_W-1:0] held_refl   = '0;
  sbi_pkg::fill_e                    window_fill = sbi_pkg::FILL_EMPTY;

  int samples_sent    = 0;
  int spectra_sent    = 0;
  int results_checked = 0;
  int settings_used   = 0;
  int mismatches      = 0;
  int burst_left      = 0;
  int gap_left        = 0;
  int stall_mode      = 0;
  int mode_left       = 0;
  int holdoff_left    = 0;
  bit holdoff_done    = 1'b0;
  int idle_cycles     = 0;
  sbi_pkg::out_t want;

  spectral_band_integrator_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int span(input int a, input int b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // add reflectance times neighbor distance sum (doubled with one neighbor) to every band holding x
  function automatic void accumulate_bands(input int x, input int r, input bit has_left,
                                           input int left, input bit has_right, input int right);
    int     lo, hi, width_sum;
    longint term, total;
    for (int k = 0; k < sbi_pkg::NUM_BANDS; k++) begin
      lo = int'(band_edges[k][15:0]);
      hi = int'(band_edges[k][31:16]);
      if (x < lo || x > hi) continue;
      width_sum = 0;
      if (has_left) width_sum += span((left < lo) ? lo : left, x);
      if (has_right) width_sum += span((right > hi) ? hi : right, x);
      term  = longint'(r) * longint'(width_sum) * ((has_left && has_right) ? 1 : 2);
      total = longint'(band_sums[k]) + term;
      if (total > longint'(sbi_pkg::ACC_MAX)) total = longint'(sbi_pkg::ACC_MAX);
      if (total < longint'(sbi_pkg::ACC_MIN)) total = longint'(sbi_pkg::ACC_MIN);
      band_sums[k] = total[sbi_pkg::ACC_W-1:0];
    end
  endfunction

  // rounded, saturated quotient of sum / (2 * width)
  function automatic logic signed [sbi_pkg::REFL_W-1:0] band_mean(input longint total,
                                                                  input int width);
    longint unsigned mag, aw, q;
    bit              neg;
    mag = (total < 0) ? -total : total;
    aw  = longint'((width < 0) ? -width : width);
    q   = (mag + aw) / (2 * aw);
    neg = (total < 0) != (width < 0);
    if (neg)
      return (q > longint'(sbi_pkg::VAL_MAX) + 1) ? sbi_pkg::VAL_MIN
                                                  : sbi_pkg::REFL_W'(-longint'(q));
    return (q > longint'(sbi_pkg::VAL_MAX)) ? sbi_pkg::VAL_MAX : q[sbi_pkg::REFL_W-1:0];
  endfunction

  function automatic void integrate_sample(input sbi_pkg::in_t s);
    bit            held;
    int            lo, hi, width;
    sbi_pkg::out_t r;
    held = (window_fill != sbi_pkg::FILL_EMPTY);
    if (held)
      accumulate_bands(int'(held_wl), int'(held_refl), window_fill == sbi_pkg::FILL_BOTH,
                       int'(prior_wl), 1'b1, int'(s.wavelength));
    if (!s.final_sample) begin
      if (held) prior_wl = held_wl;
      window_fill = held ? sbi_pkg::FILL_BOTH : sbi_pkg::FILL_NO_LEFT;
      held_wl     = s.wavelength;
      held_refl   = s.reflectance;
      return;
    end
    accumulate_bands(int'(s.wavelength), int'($signed(s.reflectance)), held, int'(held_wl),
                     1'b0, 0);
    for (int k = 0; k < sbi_pkg::NUM_BANDS; k++) begin
      lo = int'(band_edges[k][15:0]);
      hi = int'(band_edges[k][31:16]);
      width = hi - lo;
      r.band_index = sbi_pkg::BAND_W'(k);
      r.band_value = (width == 0) ? '0 : band_mean(band_sums[k], width);
      r.zero_width = (width == 0);
      r.last_band  = (k == sbi_pkg::NUM_BANDS - 1);
      band_result_queue.push_back(r);
      band_sums[k] = '0;
    end
    prior_wl    = '0;
    held_wl     = '0;
    held_refl   = '0;
    window_fill = sbi_pkg::FILL_EMPTY;
    spectra_sent++;
  endfunction

  task automatic report_mismatch(input string what, input sbi_pkg::out_t exp_r,
                                 input sbi_pkg::out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected band %0d value %0d zero_width %0b last_band %0b",
               $realtime, what, exp_r.band_index, exp_r.band_value, exp_r.zero_width,
               exp_r.last_band);
      $display("%0t %s: got band %0d value %0d zero_width %0b last_band %0b",
               $realtime, what, got.band_index, got.band_value, got.zero_width,
               got.last_band);
    end
  endtask

  task automatic push_sample(input logic [sbi_pkg::WL_W-1:0] wl,
                             input logic [sbi_pkg::REFL_W-1:0] refl, input logic fin);
    sbi_pkg::in_t s;
    s.wavelength   = wl;
    s.reflectance  = refl;
    s.final_sample = fin;
    sample_queue.push_back(s);
  endtask

  task automatic write_band_edges(input int idx, input logic [15:0] lo, input logic [15:0] hi);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= sbi_pkg::CFG_AW'(idx);
    cfg_wdata_i <= {hi, lo};
    band_edges[idx] = {hi, lo};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_random_bands(input int org);
    int lo, hi, style;
    for (int k = 0; k < sbi_pkg::NUM_BANDS; k++) begin
      style = $urandom_range(0, 9);
      lo = org + $urandom_range(0, REGION_SPAN - 1);
      case (style)
        0: hi = lo;
        1: hi = lo - $urandom_range(1, 2000);
        2: begin
          lo = 0;
          hi = WL_TOP;
        end
        3: hi = lo + $urandom_range(1, 8);
        default: hi = lo + $urandom_range(0, 3000);
      endcase
      if (hi < 0) hi = 0;
      if (hi > WL_TOP) hi = WL_TOP;
      write_band_edges(k, 16'(lo), 16'(hi));
    end
    settings_used++;
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || in_valid_i || band_result_queue.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        integrate_sample(in_data_i);
        samples_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          in_data_i  <= sample_queue.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer and drives the stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_checked++;
        if (band_result_queue.size() == 0) begin
          report_mismatch("unexpected band result", '0, out_data_o);
        end else begin
          want = band_result_queue.pop_front();
          if (want.band_index !== out_data_o.band_index ||
              want.band_value !== out_data_o.band_value ||
              want.zero_width !== out_data_o.zero_width ||
              want.last_band !== out_data_o.last_band)
            report_mismatch("band result mismatch", want, out_data_o);
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      if (!holdoff_done && results_checked >= HOLDOFF_AFTER) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int org, len, step_max, wl, wl_s, kind, phase_count;
    logic [sbi_pkg::REFL_W-1:0] refl;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset edges: every band has zero width
    settings_used++;
    push_sample(16'd0, 24'h7fffff, 1'b0);
    push_sample(16'd0, 24'h800000, 1'b1);
    wait_idle();

    write_band_edges(0, 16'd0, 16'hffff);
    write_band_edges(1, 16'd1000, 16'd2000);
    write_band_edges(2, 16'd1500, 16'd1500);
    write_band_edges(3, 16'd3000, 16'd1000);
    write_band_edges(4, 16'd0, 16'd1);
    write_band_edges(5, 16'hfffe, 16'hffff);
    write_band_edges(6, 16'd100, 16'd200);
    write_band_edges(7, 16'd1200, 16'd1300);
    settings_used++;
    // single sample spectrum
    push_sample(16'd1500, 24'h7fffff, 1'b1);
    // sorted spectrum across the whole range
    push_sample(16'd0, 24'h800000, 1'b0);
    push_sample(16'd1000, 24'h7fffff, 1'b0);
    push_sample(16'd1500, 24'h000001, 1'b0);
    push_sample(16'd2000, 24'hffffff, 1'b0);
    push_sample(16'hffff, 24'h800000, 1'b1);
    // unsorted wavelengths
    push_sample(16'd2000, 24'h012345, 1'b0);
    push_sample(16'd1000, 24'hfedcba, 1'b0);
    push_sample(16'd1800, 24'h7fffff, 1'b0);
    push_sample(16'hffff, 24'h7fffff, 1'b0);
    push_sample(16'd0, 24'h000000, 1'b1);
    // output saturation, both signs
    push_sample(16'd100, 24'h7fffff, 1'b0);
    push_sample(16'd200, 24'h7fffff, 1'b1);
    push_sample(16'd100, 24'h800000, 1'b0);
    push_sample(16'd150, 24'h800000, 1'b0);
    push_sample(16'd200, 24'h800000, 1'b1);
    // top of the wavelength range
    push_sample(16'hfffe, 24'h555555, 1'b0);
    push_sample(16'hffff, 24'haaaaaa, 1'b1);
    // rounding ties away from zero
    push_sample(16'd1200, 24'd25, 1'b0);
    push_sample(16'd1201, 24'd25, 1'b1);
    push_sample(16'd1200, -24'sd25, 1'b0);
    push_sample(16'd1201, -24'sd25, 1'b1);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0)
        org = 0;
      else if (p == RANDOM_PHASES - 1)
        org = WL_TOP + 1 - REGION_SPAN;
      else
        org = $urandom_range(0, WL_TOP + 1 - REGION_SPAN);
      program_random_bands(org);
      phase_count = 0;
      while (phase_count < PHASE_SAMPLES) begin
        kind = $urandom_range(0, 19);
        len = (kind == 0) ? 1 : (kind == 1) ? $urandom_range(20, 40) : $urandom_range(2, 12);
        step_max = $urandom_range(1, 600);
        wl = org + $urandom_range(0, REGION_SPAN / 2);
        for (int i = 0; i < len; i++) begin
          kind = $urandom_range(0, 19);
          if (kind == 0) begin
            wl_s = $urandom_range(0, WL_TOP);
          end else if (kind == 1) begin
            wl_s = wl - $urandom_range(0, 300);
            if (wl_s < 0) wl_s = 0;
          end else begin
            wl += $urandom_range(0, step_max);
            if (wl > WL_TOP) wl = WL_TOP;
            wl_s = wl;
          end
          kind = $urandom_range(0, 9);
          if (kind == 0)
            refl = sbi_pkg::VAL_MAX;
          else if (kind == 1)
            refl = sbi_pkg::VAL_MIN;
          else if (kind < 4)
            refl = sbi_pkg::REFL_W'($urandom_range(0, 131072) - 65536);
          else
            refl = sbi_pkg::REFL_W'($urandom);
          push_sample(sbi_pkg::WL_W'(wl_s), refl, i == len - 1);
          phase_count++;
        end
      end
      wait_idle();
    end

    $display("covered %0d samples in %0d spectra over %0d band settings",
             samples_sent, spectra_sent, settings_used);
    $display("checked %0d band results, %0d mismatches, %0d results never seen",
             results_checked, mismatches, band_result_queue.size());
    if (mismatches == 0 && band_result_queue.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
src/sbi_pkg.sv
src/spectral_band_integrator_unit.sv
bench/tb_top.sv
